// ===== design/mhpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int OP_W     = 1;

  localparam int DEPTH_DEF = 1024;

  localparam int S_TDATA_W = ((KEY_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((KEY_W + COUNT_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_TDATA_W - KEY_W - COUNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Kind of work a token carries from one level cell to the next.
  typedef struct packed {
    logic ins;
    logic sift;
  } tok_ctl_t;

endpackage

`default_nettype wire

// ===== design/mhpq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/mhpq_root.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mhpq_root import mhpq_pkg::*; #(
  parameter int PW = $clog2(DEPTH_DEF + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tok_ctl_t          tok_ctl_i,
  input  wire logic [PW-1:0]     tok_path_i,
  input  wire logic [KEY_W-1:0]  tok_val_i,
  input  wire logic [PW-1:0]     target_i,
  input  wire logic              wr_vld_i,
  input  wire logic [KEY_W-1:0]  wr_val_i,
  output logic      [KEY_W-1:0]  root_o,
  output tok_ctl_t               tok_ctl_o,
  output logic      [PW-1:0]     tok_pos_o,
  output logic      [PW-1:0]     tok_path_o,
  output logic      [KEY_W-1:0]  tok_val_o,
  output logic                   done_o
);

  logic [KEY_W-1:0] root_q, root_d;
  logic             root_we;
  tok_ctl_t         ctl_q, ctl_d;
  logic [PW-1:0]    pos_q, pos_d, path_q, path_d;
  logic [KEY_W-1:0] val_q, val_d;
  logic             done_q, done_d;

  always_comb begin
    root_we = 1'b0;
    root_d  = tok_val_i;
    ctl_d   = '0;
    pos_d   = PW'({1'b1, tok_path_i[PW-1]});
    path_d  = tok_path_i << 1;
    val_d   = tok_val_i;
    done_d  = 1'b0;
    if (tok_ctl_i.ins) begin
      if (target_i == PW'(1)) begin
        root_we = 1'b1;
        done_d  = 1'b1;
      end else begin
        ctl_d.ins = 1'b1;
        if (tok_val_i > root_q) begin
          root_we = 1'b1;
          val_d   = root_q;
        end
      end
    end else if (wr_vld_i) begin
      root_we = 1'b1;
      root_d  = wr_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (root_we) begin
      root_q <= root_d;
    end
    pos_q  <= pos_d;
    path_q <= path_d;
    val_q  <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ctl_q  <= ctl_d;
      done_q <= done_d;
    end
  end

  assign root_o     = root_q;
  assign tok_ctl_o  = ctl_q;
  assign tok_pos_o  = pos_q;
  assign tok_path_o = path_q;
  assign tok_val_o  = val_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

// ===== design/mhpq_level.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mhpq_level import mhpq_pkg::*; #(
  parameter int HEAP_DEPTH = DEPTH_DEF,
  parameter int PW         = $clog2(DEPTH_DEF + 1),
  parameter int LEVEL      = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tok_ctl_t          tok_ctl_i,
  input  wire logic [PW-1:0]     tok_pos_i,
  input  wire logic [PW-1:0]     tok_path_i,
  input  wire logic [KEY_W-1:0]  tok_val_i,
  input  wire logic [PW-1:0]     target_i,
  input  wire logic [PW-1:0]     cnt_i,
  input  wire logic              fetch_vld_i,
  input  wire logic [PW-1:0]     fetch_pos_i,
  input  wire logic              wr_vld_i,
  input  wire logic [PW-1:0]     wr_pos_i,
  input  wire logic [KEY_W-1:0]  wr_val_i,
  output tok_ctl_t               tok_ctl_o,
  output logic      [PW-1:0]     tok_pos_o,
  output logic      [PW-1:0]     tok_path_o,
  output logic      [KEY_W-1:0]  tok_val_o,
  output logic                   wr_vld_o,
  output logic      [PW-1:0]     wr_pos_o,
  output logic      [KEY_W-1:0]  wr_val_o,
  output logic                   rsp_vld_o,
  output logic      [KEY_W-1:0]  rsp_val_o,
  output logic                   done_o
);

  localparam int LO      = 1 << LEVEL;
  localparam int HI_FULL = (1 << (LEVEL + 1)) - 1;
  localparam int HI      = (HI_FULL < HEAP_DEPTH) ? HI_FULL : HEAP_DEPTH;
  localparam int ROWS    = ((HI - LO) / 2) + 1;
  localparam int AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [PW-1:0] ROW_MASK = PW'((1 << (LEVEL - 1)) - 1);
  localparam bit LAST    = (LEVEL == PW - 1);

  // Entries of this level are kept as sibling pairs: even positions on the
  // left memory, odd positions on the right one, one row per parent.
  function automatic logic [AW-1:0] row_of(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p >> 1) & ROW_MASK;
    return r[AW-1:0];
  endfunction

  tok_ctl_t         ctl_q;
  logic [PW-1:0]    pos_q, path_q;
  logic [KEY_W-1:0] val_q;
  logic             fetch_hit_q, fetch_side_q;

  logic [AW-1:0]    raddr, waddr;
  logic [KEY_W-1:0] rd_l, rd_r, wdata;
  logic             we, wside;

  logic             own_we;
  logic [PW-1:0]    own_pos;
  logic [KEY_W-1:0] own_val;

  logic [KEY_W-1:0] sel, cmp, wv;
  logic [PW-1:0]    lpos, rpos, child;
  logic             lex, rex, bl, br;

  tok_ctl_t         nctl_d, nctl_q;
  logic [PW-1:0]    npos_d, npos_q, npath_d, npath_q;
  logic [KEY_W-1:0] nval_d, nval_q;
  logic             wrv_d, wrv_q;
  logic [KEY_W-1:0] wrval_d, wrval_q;
  logic [PW-1:0]    wrpos_q;
  logic             done_d, done_q;

  always_comb begin
    if (fetch_vld_i) begin
      raddr = row_of(fetch_pos_i);
    end else if (tok_ctl_i.sift) begin
      raddr = row_of({tok_pos_i[PW-2:0], 1'b0});
    end else begin
      raddr = row_of(tok_pos_i);
    end
  end

  always_comb begin
    sel   = pos_q[0] ? rd_r : rd_l;
    lpos  = {pos_q[PW-2:0], 1'b0};
    rpos  = {pos_q[PW-2:0], 1'b1};
    lex   = (lpos <= cnt_i);
    rex   = (rpos <= cnt_i);
    bl    = lex && (rd_l > val_q);
    cmp   = bl ? rd_l : val_q;
    br    = rex && (rd_r > cmp);
    wv    = br ? rd_r : cmp;
    child = br ? rpos : lpos;

    own_we  = 1'b0;
    own_pos = pos_q;
    own_val = val_q;
    nctl_d  = '0;
    npos_d  = {pos_q[PW-2:0], path_q[PW-1]};
    npath_d = path_q << 1;
    nval_d  = val_q;
    wrv_d   = 1'b0;
    wrval_d = wv;
    done_d  = 1'b0;

    if (ctl_q.ins) begin
      if (pos_q == target_i) begin
        own_we = 1'b1;
        done_d = 1'b1;
      end else begin
        nctl_d.ins = 1'b1;
        if (val_q > sel) begin
          own_we = 1'b1;
          nval_d = sel;
        end
      end
    end else if (ctl_q.sift) begin
      wrv_d = 1'b1;
      if (bl || br) begin
        if (LAST) begin
          own_we  = 1'b1;
          own_pos = child;
          done_d  = 1'b1;
        end else begin
          nctl_d.sift = 1'b1;
          npos_d      = child;
        end
      end else begin
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    if (wr_vld_i) begin
      we    = 1'b1;
      waddr = row_of(wr_pos_i);
      wside = wr_pos_i[0];
      wdata = wr_val_i;
    end else begin
      we    = own_we;
      waddr = row_of(own_pos);
      wside = own_pos[0];
      wdata = own_val;
    end
  end

  mhpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ROWS),
    .AW    (AW)
  ) u_ram_l (
    .clk_i   (clk_i),
    .we_i    (we && !wside),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_l)
  );

  mhpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ROWS),
    .AW    (AW)
  ) u_ram_r (
    .clk_i   (clk_i),
    .we_i    (we && wside),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_r)
  );

  always_ff @(posedge clk_i) begin
    pos_q        <= tok_pos_i;
    path_q       <= tok_path_i;
    val_q        <= tok_val_i;
    fetch_side_q <= fetch_pos_i[0];
    npos_q       <= npos_d;
    npath_q      <= npath_d;
    nval_q       <= nval_d;
    wrpos_q      <= pos_q;
    wrval_q      <= wrval_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= '0;
      fetch_hit_q <= 1'b0;
      nctl_q      <= '0;
      wrv_q       <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      ctl_q       <= tok_ctl_i;
      fetch_hit_q <= fetch_vld_i && ((fetch_pos_i >> LEVEL) == PW'(1));
      nctl_q      <= nctl_d;
      wrv_q       <= wrv_d;
      done_q      <= done_d;
    end
  end

  assign tok_ctl_o  = nctl_q;
  assign tok_pos_o  = npos_q;
  assign tok_path_o = npath_q;
  assign tok_val_o  = nval_q;
  assign wr_vld_o   = wrv_q;
  assign wr_pos_o   = wrpos_q;
  assign wr_val_o   = wrval_q;
  assign rsp_vld_o  = fetch_hit_q;
  assign rsp_val_o  = fetch_hit_q ? (fetch_side_q ? rd_r : rd_l) : '0;
  assign done_o     = done_q;

endmodule

`default_nettype wire

// ===== design/max_heap_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Binary max-heap priority queue. Each request is an insert of a 31-bit key
// (tuser 0) or an extract of the maximum (tuser 1). Every request gives one
// response with the extracted key (zero otherwise), a status (0 ok, 1 extract
// on an empty heap, 2 insert dropped because the heap is full) and the number
// of entries held afterwards. Duplicate keys are kept. The heap is a chain of
// L = clog2(HEAP_DEPTH + 1) level cells: a root register, then one cell per
// tree level with its own pair of memories, so a sift step touches one level
// per cell. At each level the memory read is registered, then the cell
// compares and writes. An extract from two or more entries first fetches
// the last entry and then sifts it down. An extract on an empty heap, an
// insert into a full heap and an extract of the only entry go straight to
// the response without passing through the level cells. One request is
// worked on at a time, and the next one is taken in the cycle after the
// previous response is loaded into the output register, even while that
// response still waits there. No memory clearing is needed after reset.
module max_heap_priority_queue import mhpq_pkg::*; #(
  parameter int HEAP_DEPTH = DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,  // key, zero pad
  input  wire logic [OP_W-1:0]      s_axis_tuser_i,  // op
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic      [M_TDATA_W-1:0] m_axis_tdata_o,  // value, count, zero pad
  output logic      [STATUS_W-1:0]  m_axis_tuser_o   // status
);

  localparam int PW = $clog2(HEAP_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS    = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_SIFT   = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  // Path bits below the leading one of x, aligned to the top.
  function automatic logic [PW-1:0] path_of(input logic [PW-1:0] x);
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < PW; i++) begin
      if (x[i]) begin
        p = x << (PW - i);
      end
    end
    return p;
  endfunction

  logic [2:0]       state_q, state_d;
  logic [PW-1:0]    cnt_q, cnt_d, target_q, target_d, cnt_inc;
  logic [KEY_W-1:0] res_val_q, res_val_d;
  status_e          res_st_q, res_st_d;

  tok_ctl_t         ins_ctl_q, ins_ctl_d;
  logic [PW-1:0]    ins_path_q, ins_path_d;
  logic [KEY_W-1:0] ins_val_q, ins_val_d;
  logic             sift_vld_q, sift_vld_d;
  logic [KEY_W-1:0] sift_val_q, sift_val_d;
  logic             fetch_vld_q, fetch_vld_d;

  logic             m_valid_q, m_valid_d, m_load;
  logic [KEY_W-1:0] m_value_q;
  logic [COUNT_W-1:0] m_count_q;
  status_e          m_status_q;

  logic             in_acc;
  op_e              op;
  logic [KEY_W-1:0] key;

  logic [KEY_W-1:0] root_val;
  tok_ctl_t         r_ctl;
  logic [PW-1:0]    r_pos, r_path;
  logic [KEY_W-1:0] r_val;

  tok_ctl_t         c1_ctl;
  logic [PW-1:0]    c1_pos, c1_path;
  logic [KEY_W-1:0] c1_val;

  tok_ctl_t         co_ctl  [1:PW-1];
  logic [PW-1:0]    co_pos  [1:PW-1];
  logic [PW-1:0]    co_path [1:PW-1];
  logic [KEY_W-1:0] co_val  [1:PW-1];
  logic             wo_vld  [1:PW-1];
  logic [PW-1:0]    wo_pos  [1:PW-1];
  logic [KEY_W-1:0] wo_val  [1:PW-1];
  logic [KEY_W-1:0] rsp_val_arr [1:PW-1];
  logic [PW-1:1]    rsp_vld_vec;
  logic [PW-1:0]    done_vec;

  logic             rsp_any, done_any;
  logic [KEY_W-1:0] rsp_val;

  assign op      = op_e'(s_axis_tuser_i);
  assign key     = s_axis_tdata_i[KEY_W-1:0];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_inc = cnt_q + PW'(1);

  mhpq_root #(
    .PW (PW)
  ) u_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok_ctl_i  (ins_ctl_q),
    .tok_path_i (ins_path_q),
    .tok_val_i  (ins_val_q),
    .target_i   (target_q),
    .wr_vld_i   (wo_vld[1]),
    .wr_val_i   (wo_val[1]),
    .root_o     (root_val),
    .tok_ctl_o  (r_ctl),
    .tok_pos_o  (r_pos),
    .tok_path_o (r_path),
    .tok_val_o  (r_val),
    .done_o     (done_vec[0])
  );

  always_comb begin
    if (sift_vld_q) begin
      c1_ctl      = '0;
      c1_ctl.sift = 1'b1;
      c1_pos      = PW'(1);
      c1_path     = '0;
      c1_val      = sift_val_q;
    end else begin
      c1_ctl  = r_ctl;
      c1_pos  = r_pos;
      c1_path = r_path;
      c1_val  = r_val;
    end
  end

  for (genvar k = 1; k < PW; k++) begin : g_level
    tok_ctl_t         in_ctl;
    logic [PW-1:0]    in_pos, in_path, wi_pos;
    logic [KEY_W-1:0] in_val, wi_val;
    logic             wi_vld;

    if (k == 1) begin : g_first
      assign in_ctl  = c1_ctl;
      assign in_pos  = c1_pos;
      assign in_path = c1_path;
      assign in_val  = c1_val;
    end else begin : g_chain
      assign in_ctl  = co_ctl[k-1];
      assign in_pos  = co_pos[k-1];
      assign in_path = co_path[k-1];
      assign in_val  = co_val[k-1];
    end

    if (k == PW - 1) begin : g_tail
      assign wi_vld = 1'b0;
      assign wi_pos = '0;
      assign wi_val = '0;
    end else begin : g_mid
      assign wi_vld = wo_vld[k+1];
      assign wi_pos = wo_pos[k+1];
      assign wi_val = wo_val[k+1];
    end

    mhpq_level #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .PW         (PW),
      .LEVEL      (k)
    ) u_level (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_ctl_i   (in_ctl),
      .tok_pos_i   (in_pos),
      .tok_path_i  (in_path),
      .tok_val_i   (in_val),
      .target_i    (target_q),
      .cnt_i       (cnt_q),
      .fetch_vld_i (fetch_vld_q),
      .fetch_pos_i (cnt_q),
      .wr_vld_i    (wi_vld),
      .wr_pos_i    (wi_pos),
      .wr_val_i    (wi_val),
      .tok_ctl_o   (co_ctl[k]),
      .tok_pos_o   (co_pos[k]),
      .tok_path_o  (co_path[k]),
      .tok_val_o   (co_val[k]),
      .wr_vld_o    (wo_vld[k]),
      .wr_pos_o    (wo_pos[k]),
      .wr_val_o    (wo_val[k]),
      .rsp_vld_o   (rsp_vld_vec[k]),
      .rsp_val_o   (rsp_val_arr[k]),
      .done_o      (done_vec[k])
    );
  end

  always_comb begin
    rsp_any = 1'b0;
    rsp_val = '0;
    for (int k = 1; k < PW; k++) begin
      rsp_any = rsp_any | rsp_vld_vec[k];
      rsp_val = rsp_val | rsp_val_arr[k];
    end
  end

  assign done_any = |done_vec;
  assign m_load   = (state_q == S_RESULT) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    target_d    = target_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    ins_ctl_d   = '0;
    ins_path_d  = path_of(cnt_inc);
    ins_val_d   = key;
    sift_vld_d  = 1'b0;
    sift_val_d  = rsp_val;
    fetch_vld_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_val_d = '0;
          res_st_d  = ST_OK;
          if (op == OP_INSERT) begin
            if (cnt_q >= PW'(HEAP_DEPTH)) begin
              res_st_d = ST_FULL;
              state_d  = S_RESULT;
            end else begin
              cnt_d         = cnt_inc;
              target_d      = cnt_inc;
              ins_ctl_d.ins = 1'b1;
              state_d       = S_INS;
            end
          end else begin
            if (cnt_q == '0) begin
              res_st_d = ST_EMPTY;
              state_d  = S_RESULT;
            end else begin
              res_val_d = root_val;
              if (cnt_q == PW'(1)) begin
                cnt_d   = '0;
                state_d = S_RESULT;
              end else begin
                fetch_vld_d = 1'b1;
                state_d     = S_FETCH;
              end
            end
          end
        end
      end
      S_FETCH: begin
        if (rsp_any) begin
          cnt_d      = cnt_q - PW'(1);
          sift_vld_d = 1'b1;
          state_d    = S_SIFT;
        end
      end
      S_INS, S_SIFT: begin
        if (done_any) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (m_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q   <= target_d;
    res_val_q  <= res_val_d;
    res_st_q   <= res_st_d;
    ins_path_q <= ins_path_d;
    ins_val_q  <= ins_val_d;
    sift_val_q <= sift_val_d;
    if (m_load) begin
      m_value_q  <= res_val_q;
      m_status_q <= res_st_q;
      m_count_q  <= COUNT_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ins_ctl_q   <= '0;
      sift_vld_q  <= 1'b0;
      fetch_vld_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ins_ctl_q   <= ins_ctl_d;
      sift_vld_q  <= sift_vld_d;
      fetch_vld_q <= fetch_vld_d;
      m_valid_q   <= m_valid_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{M_PAD_W{1'b0}}, m_count_q, m_value_q};
  assign m_axis_tuser_o  = m_status_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PW'(HEAP_DEPTH))
    else $error("entry count above heap depth");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_any |-> (state_q == S_INS || state_q == S_SIFT))
    else $error("level cell finished while no operation was running");

  a_one_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(rsp_vld_vec) && (!rsp_any || state_q == S_FETCH))
    else $error("bad fetch response from level cells");

  a_tail_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(co_ctl[PW-1].ins || co_ctl[PW-1].sift))
    else $error("token passed beyond the deepest level");

  a_root_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wo_vld[1] |-> (wo_pos[1] == PW'(1) && state_q == S_SIFT))
    else $error("unexpected write toward the root");

endmodule

`default_nettype wire
